### hdl/rua_pkg.sv
// ----------------------------------------------------------------------------
// rua_pkg
// Types and constants shared by the rectangle union area sweep modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rua_pkg;

   localparam int COORD_W = 15;
   localparam int AREA_W  = 40;
   localparam int LEN_W   = 16;

   localparam logic ACTION_EDGE  = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   localparam logic [1:0] FAULT_OK        = 2'd0;
   localparam logic [1:0] FAULT_X_BACK    = 2'd1;
   localparam logic [1:0] FAULT_COUNT_SAT = 2'd2;
   localparam logic [1:0] FAULT_AREA_SAT  = 2'd3;

   localparam logic [1:0] STAGE_ENTER = 2'd0;
   localparam logic [1:0] STAGE_LEFT  = 2'd1;
   localparam logic [1:0] STAGE_RIGHT = 2'd2;

   typedef struct packed {
      logic               action;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y_low;
      logic [COORD_W-1:0] y_high;
      logic               is_end;
   } req_type;

   typedef struct packed {
      logic [AREA_W-1:0] area;
      logic [LEN_W-1:0]  covered_length;
      logic [1:0]        fault;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic clr_init;
      logic clr_step;
      logic mul;
      logic add;
      logic go_left;
      logic go_right;
      logic pop;
      logic rd0;
      logic rd1;
      logic wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic       is_clear;
      logic [1:0] stage;
      logic       disjoint;
      logic       full;
      logic       sp_zero;
      logic       clr_last;
   } sts_type;

endpackage

`default_nettype wire

### hdl/rua_ram.sv
// ----------------------------------------------------------------------------
// rua_ram
// Generic single port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rua_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hdl/rua_ctrl.sv
// ----------------------------------------------------------------------------
// rua_ctrl
// Sequencer: clearing sweep, area update and segment tree walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rua_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire rua_pkg::sts_type sts,
   output      rua_pkg::cmd_type cmd
);

   import rua_pkg::*;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_ADD   = 4'd3;
   localparam logic [3:0] S_VISIT = 4'd4;
   localparam logic [3:0] S_RD0   = 4'd5;
   localparam logic [3:0] S_RD1   = 4'd6;
   localparam logic [3:0] S_WR    = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       reply_ff, reply_in;
   logic       valid_ff, valid_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      reply_in = reply_ff;
      cmd      = '0;
      case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = reply_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.take = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (sts.is_clear) begin
               cmd.clr_init = 1'b1;
               reply_in     = 1'b1;
               state_in     = S_CLR;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_VISIT;
         end
         S_VISIT: begin
            case (sts.stage)
               STAGE_ENTER: begin
                  if (sts.disjoint) begin
                     if (sts.sp_zero) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.pop = 1'b1;
                     end
                  end else if (sts.full) begin
                     state_in = S_RD0;
                  end else begin
                     cmd.go_left = 1'b1;
                  end
               end
               STAGE_LEFT: begin
                  cmd.go_right = 1'b1;
               end
               default: begin
                  state_in = S_RD0;
               end
            endcase
         end
         S_RD0: begin
            cmd.rd0  = 1'b1;
            state_in = S_RD1;
         end
         S_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            cmd.wr = 1'b1;
            if (sts.sp_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_VISIT;
            end
         end
         S_DONE: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               reply_in     = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         reply_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
         valid_ff <= valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_MUL)
      else $error("accepted item did not start processing");

   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WR |-> $past(state_ff) == S_RD1)
      else $error("node write without read sequence");

   a_clr_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR && sts.clr_last) |=> (state_ff == S_IDLE || state_ff == S_DONE))
      else $error("clearing sweep did not finish");

endmodule

`default_nettype wire

### hdl/rua_dp.sv
// ----------------------------------------------------------------------------
// rua_dp
// Datapath: node memories, walk stack, area accumulator, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rua_dp #(
   parameter int Y_SPAN      = 32768,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rua_pkg::req_type req_data,
   input  wire rua_pkg::cmd_type cmd,
   output      rua_pkg::sts_type sts,
   output      rua_pkg::rsp_type rsp_data
);

   import rua_pkg::*;

   localparam int YW         = $clog2(Y_SPAN);
   localparam int NODE_DEPTH = 4 * Y_SPAN;
   localparam int AW         = $clog2(NODE_DEPTH);
   localparam int SD         = YW + 1;
   localparam int SPW        = $clog2(SD);
   localparam int LW         = YW + 1;
   localparam int CMPW       = (YW > COORD_W) ? YW : COORD_W;
   localparam int PW         = COORD_W + LW;

   typedef struct packed {
      logic [AW-1:0] node;
      logic [YW-1:0] lo;
      logic [YW-1:0] hi;
      logic [1:0]    stage;
   } frame_type;

   req_type           req_ff;
   frame_type         stk_ff [SD];
   logic [SPW-1:0]    sp_ff;
   logic [AW-1:0]     sweep_ff;
   logic [AREA_W-1:0] area_ff;
   logic [COORD_W-1:0] last_x_ff;
   logic              have_ff;
   logic [LW-1:0]     root_cov_ff;
   logic [PW-1:0]     prod_ff;
   logic              x_back_ff;
   logic              area_sat_ff;
   logic              count_sat_ff;
   logic [COUNT_WIDTH-1:0] cnt_q_ff;
   logic [LW-1:0]     c0_q_ff;
   rsp_type           rsp_ff;

   frame_type         top_fr;
   logic [SPW-1:0]    sp_up;
   logic [YW-1:0]     mid;
   logic [AW-1:0]     child0;
   logic [AW-1:0]     child1;
   logic [CMPW-1:0]   q_lo, q_hi, n_lo, n_hi;
   logic              leaf;
   logic [LW-1:0]     len;

   logic [AW-1:0]          cnt_addr, cov_addr;
   logic                   ram_we;
   logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
   logic [LW-1:0]          cov_wdata, cov_rdata;
   logic [COUNT_WIDTH-1:0] new_cnt;
   logic                   sat_hit;
   logic [LW-1:0]          new_cov;

   logic [COORD_W-1:0] diff;
   logic               x_back;
   logic [AREA_W:0]    sum;

   assign top_fr = stk_ff[sp_ff];
   assign sp_up  = sp_ff + SPW'(1);
   assign mid    = top_fr.lo + ((top_fr.hi - top_fr.lo) >> 1);
   assign child0 = {top_fr.node[AW-2:0], 1'b0};
   assign child1 = {top_fr.node[AW-2:0], 1'b1};
   assign q_lo   = CMPW'(req_ff.y_low);
   assign q_hi   = CMPW'(req_ff.y_high);
   assign n_lo   = CMPW'(top_fr.lo);
   assign n_hi   = CMPW'(top_fr.hi);
   assign leaf   = (top_fr.lo == top_fr.hi);
   assign len    = LW'(top_fr.hi) - LW'(top_fr.lo) + LW'(1);

   assign sts.is_clear = (req_ff.action == ACTION_CLEAR);
   assign sts.stage    = top_fr.stage;
   assign sts.disjoint = (n_hi < q_lo) || (q_hi < n_lo);
   assign sts.full     = (q_lo <= n_lo) && (n_hi <= q_hi);
   assign sts.sp_zero  = (sp_ff == '0);
   assign sts.clr_last = (sweep_ff == AW'(NODE_DEPTH - 1));

   // new count and cover of the node on top of the stack
   always_comb begin
      new_cnt = cnt_q_ff;
      sat_hit = 1'b0;
      if (top_fr.stage == STAGE_ENTER) begin
         if (req_ff.is_end) begin
            if (cnt_q_ff == '0) begin
               sat_hit = 1'b1;
            end else begin
               new_cnt = cnt_q_ff - COUNT_WIDTH'(1);
            end
         end else begin
            if (cnt_q_ff == '1) begin
               sat_hit = 1'b1;
            end else begin
               new_cnt = cnt_q_ff + COUNT_WIDTH'(1);
            end
         end
      end
      if (new_cnt != '0) begin
         new_cov = len;
      end else if (leaf) begin
         new_cov = '0;
      end else begin
         new_cov = c0_q_ff + cov_rdata;
      end
   end

   always_comb begin
      ram_we    = cmd.clr_step || cmd.wr;
      cnt_addr  = cmd.clr_step ? sweep_ff : top_fr.node;
      cov_addr  = top_fr.node;
      cnt_wdata = cmd.clr_step ? '0 : new_cnt;
      cov_wdata = cmd.clr_step ? '0 : new_cov;
      if (cmd.clr_step) begin
         cov_addr = sweep_ff;
      end else if (cmd.rd0) begin
         cov_addr = child0;
      end else if (cmd.rd1) begin
         cov_addr = child1;
      end
   end

   rua_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NODE_DEPTH)) u_cnt_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (cnt_addr),
      .wdata (cnt_wdata),
      .rdata (cnt_rdata)
   );

   rua_ram #(.WIDTH(LW), .DEPTH(NODE_DEPTH)) u_cov_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (cov_addr),
      .wdata (cov_wdata),
      .rdata (cov_rdata)
   );

   assign diff   = req_ff.x - last_x_ff;
   assign x_back = have_ff && (req_ff.x < last_x_ff);
   assign sum    = {1'b0, area_ff} + (AREA_W + 1)'(prod_ff);

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         req_ff <= req_data;
      end
      if (cmd.mul) begin
         prod_ff <= (have_ff && !x_back) ? PW'(diff * root_cov_ff) : '0;
      end
      if (cmd.add) begin
         stk_ff[0] <= '{node: AW'(1), lo: '0, hi: YW'(Y_SPAN - 1), stage: STAGE_ENTER};
      end
      if (cmd.go_left) begin
         stk_ff[sp_ff].stage <= STAGE_LEFT;
         stk_ff[sp_up] <= '{node: child0, lo: top_fr.lo, hi: mid, stage: STAGE_ENTER};
      end
      if (cmd.go_right) begin
         stk_ff[sp_ff].stage <= STAGE_RIGHT;
         stk_ff[sp_up] <= '{node: child1, lo: mid + YW'(1), hi: top_fr.hi,
                            stage: STAGE_ENTER};
      end
      if (cmd.rd1) begin
         cnt_q_ff <= cnt_rdata;
         c0_q_ff  <= cov_rdata;
      end
      if (cmd.rsp_load) begin
         rsp_ff.area           <= area_ff;
         rsp_ff.covered_length <= LEN_W'(root_cov_ff);
         if (sts.is_clear) begin
            rsp_ff.fault <= FAULT_OK;
         end else if (x_back_ff) begin
            rsp_ff.fault <= FAULT_X_BACK;
         end else if (area_sat_ff) begin
            rsp_ff.fault <= FAULT_AREA_SAT;
         end else if (count_sat_ff) begin
            rsp_ff.fault <= FAULT_COUNT_SAT;
         end else begin
            rsp_ff.fault <= FAULT_OK;
         end
      end
   end

   // sweep state
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_init) begin
         sp_ff        <= '0;
         sweep_ff     <= '0;
         area_ff      <= '0;
         last_x_ff    <= '0;
         have_ff      <= 1'b0;
         root_cov_ff  <= '0;
         x_back_ff    <= 1'b0;
         area_sat_ff  <= 1'b0;
         count_sat_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            sweep_ff <= sweep_ff + AW'(1);
         end
         if (cmd.mul) begin
            x_back_ff <= x_back;
         end
         if (cmd.add) begin
            sp_ff        <= '0;
            count_sat_ff <= 1'b0;
            last_x_ff    <= req_ff.x;
            have_ff      <= 1'b1;
            if (sum[AREA_W]) begin
               area_ff     <= '1;
               area_sat_ff <= 1'b1;
            end else begin
               area_ff     <= sum[AREA_W-1:0];
               area_sat_ff <= 1'b0;
            end
         end
         if (cmd.go_left || cmd.go_right) begin
            sp_ff <= sp_up;
         end
         if (cmd.pop) begin
            sp_ff <= sp_ff - SPW'(1);
         end
         if (cmd.wr) begin
            if (sat_hit) begin
               count_sat_ff <= 1'b1;
            end
            if (top_fr.node == AW'(1)) begin
               root_cov_ff <= new_cov;
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

   a_stack_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.go_left || cmd.go_right) |-> sp_ff != SPW'(SD - 1))
      else $error("walk stack overflow");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      root_cov_ff <= LW'(Y_SPAN))
      else $error("root cover beyond span");

   a_area_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.clr_init) && !$past(reset) |-> area_ff >= $past(area_ff))
      else $error("area decreased without clear");

endmodule

`default_nettype wire

### hdl/rectangle_union_area_sweep_top.sv
// ----------------------------------------------------------------------------
// rectangle_union_area_sweep_top
// Union area of axis-aligned rectangles by a sweep over x with a coverage
// segment tree over y cells.
// ----------------------------------------------------------------------------
// Items arrive on req_ (valid/stall) sorted by x; each gives one item on rsp_
// with the running area, the covered y length and a fault code.
// An edge item runs the multiply and add steps and then a tree walk: each node
// the walk reaches gets a visit, a node that splits is visited again after
// each child, and an updated node gets two node memory reads and a write; the
// walk touches up to about four nodes per level of a tree of log2(Y_SPAN)+1
// levels. Node memories are single ported, so node reads and writes take turns.
// A clear item and reset both run a sweep over all 4*Y_SPAN node slots, one a
// cycle; req_stall is high during it. Reset gives no result item, clear does.
// One item is worked at a time; the next item is taken while a result waits
// in the output register, and work stops before loading a new result while
// rsp_stall holds the previous one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rectangle_union_area_sweep_top #(
   parameter int Y_SPAN      = 32768,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire rua_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      rua_pkg::rsp_type rsp_data
);

   import rua_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rua_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rua_dp #(.Y_SPAN(Y_SPAN), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rectangle union area sweep block.
// ----------------------------------------------------------------------------
// An initial block queues directed edge and clear items and then random sweeps of
// properly opened and closed rectangles with some noise mixed in. A clocked
// driver sends them in bursts. A clocked monitor checks each result item
// against a segment tree model kept here, while the receiver stalls on a
// changing pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import rua_pkg::*;

   localparam int          Y_SPAN      = 32768;
   localparam int          COUNT_WIDTH = 16;
   localparam int unsigned SLOTS       = 4 * Y_SPAN;
   localparam longint      AREA_MAX    = (64'd1 << AREA_W) - 1;
   localparam longint      COUNT_MAX   = (64'd1 << COUNT_WIDTH) - 1;
   localparam int          LIMIT       = 4000000;
   localparam int          N_RANDOM    = 930;
   localparam int          MAX_OPEN    = 12;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rectangle_union_area_sweep_top #(
      .Y_SPAN(Y_SPAN), .COUNT_WIDTH(COUNT_WIDTH)
   ) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // model state
   int unsigned node_count [SLOTS];
   int unsigned node_cover [SLOTS];
   longint      swept_area;
   int unsigned prev_x;
   bit          seen_edge;
   bit          count_hit;

   req_type pending_items[$];
   rsp_type expected_rsp[$];
   int      mismatches = 0;
   int      cycles = 0;
   int      items_sent = 0;
   int      rsp_seen = 0;
   int      clears_sent = 0;

   function automatic int unsigned cover_at(int unsigned node);
      return (node < SLOTS) ? node_cover[node] : 0;
   endfunction

   function automatic void cover_update(int unsigned node, int unsigned lo, int unsigned hi,
                                        int unsigned qlo, int unsigned qhi, bit remove);
      int unsigned mid;
      if (node >= SLOTS) return;
      if (hi < qlo || qhi < lo) return;
      if (qlo <= lo && hi <= qhi) begin
         if (remove) begin
            if (node_count[node] == 0) count_hit = 1'b1;
            else node_count[node] = node_count[node] - 1;
         end else begin
            if (longint'(node_count[node]) >= COUNT_MAX) count_hit = 1'b1;
            else node_count[node] = node_count[node] + 1;
         end
      end else begin
         mid = lo + ((hi - lo) >> 1);
         cover_update(2 * node, lo, mid, qlo, qhi, remove);
         cover_update(2 * node + 1, mid + 1, hi, qlo, qhi, remove);
      end
      if (node_count[node] != 0) node_cover[node] = hi - lo + 1;
      else if (lo == hi) node_cover[node] = 0;
      else node_cover[node] = cover_at(2 * node) + cover_at(2 * node + 1);
   endfunction

   function automatic void sweep_clear();
      for (int i = 0; i < SLOTS; i++) begin
         node_count[i] = 0;
         node_cover[i] = 0;
      end
      swept_area = 0;
      prev_x = 0;
      seen_edge = 1'b0;
   endfunction

   function automatic rsp_type sweep_predict(req_type it);
      rsp_type r;
      bit      x_back;
      bit      area_hit;
      longint  add;
      x_back = 1'b0;
      area_hit = 1'b0;
      r = '0;
      if (it.action == ACTION_CLEAR) begin
         sweep_clear();
         return r;
      end
      if (seen_edge) begin
         if (it.x < prev_x) x_back = 1'b1;
         else begin
            add = longint'(it.x - prev_x) * longint'(node_cover[1]);
            if (add > AREA_MAX - swept_area) begin
               swept_area = AREA_MAX;
               area_hit = 1'b1;
            end else swept_area += add;
         end
      end
      count_hit = 1'b0;
      cover_update(1, 0, Y_SPAN - 1, it.y_low, it.y_high, it.is_end);
      prev_x = it.x;
      seen_edge = 1'b1;
      r.area = swept_area[AREA_W-1:0];
      r.covered_length = node_cover[1][LEN_W-1:0];
      if (x_back) r.fault = FAULT_X_BACK;
      else if (area_hit) r.fault = FAULT_AREA_SAT;
      else if (count_hit) r.fault = FAULT_COUNT_SAT;
      else r.fault = FAULT_OK;
      return r;
   endfunction

   function automatic req_type edge_item(int unsigned x, int unsigned lo, int unsigned hi,
                                         bit is_end);
      req_type it;
      it.action = ACTION_EDGE;
      it.x = x[COORD_W-1:0];
      it.y_low = lo[COORD_W-1:0];
      it.y_high = hi[COORD_W-1:0];
      it.is_end = is_end;
      return it;
   endfunction

   function automatic req_type clear_item();
      req_type it;
      it = '0;
      it.action = ACTION_CLEAR;
      it.x = COORD_W'($urandom);
      it.y_low = COORD_W'($urandom);
      it.y_high = COORD_W'($urandom);
      it.is_end = 1'($urandom);
      return it;
   endfunction

   // stimulus build
   int unsigned sweep_x;
   int unsigned open_lo[$];
   int unsigned open_hi[$];
   int unsigned lo_v, hi_v, pick, roll;

   initial begin
      sweep_clear();
      // directed edges and clears
      pending_items.push_back(edge_item(0, 0, 32767, 0));
      pending_items.push_back(edge_item(32767, 0, 32767, 1));
      pending_items.push_back(edge_item(32767, 0, 0, 1));
      pending_items.push_back(edge_item(100, 5, 9, 0));
      pending_items.push_back(edge_item(200, 9, 5, 0));
      pending_items.push_back(edge_item(300, 32767, 32767, 0));
      pending_items.push_back(edge_item(400, 0, 32767, 0));
      pending_items.push_back(edge_item(500, 0, 32767, 0));
      pending_items.push_back(edge_item(600, 16383, 16384, 1));
      pending_items.push_back(edge_item(32767, 0, 32767, 1));
      pending_items.push_back(clear_item());
      pending_items.push_back(edge_item(10, 3, 3, 0));
      pending_items.push_back(edge_item(20, 1, 7, 0));
      pending_items.push_back(edge_item(30, 1, 7, 1));
      pending_items.push_back(edge_item(40, 3, 3, 1));
      pending_items.push_back(edge_item(50, 21845, 10922, 1));
      pending_items.push_back(edge_item(60, 10922, 21845, 1));
      pending_items.push_back(clear_item());
      // random sweeps
      sweep_x = 0;
      for (int n = 0; n < N_RANDOM; n++) begin
         roll = $urandom_range(0, 99);
         if (n == 320 || n == 640) begin
            pending_items.push_back(clear_item());
            sweep_x = 0;
            open_lo.delete();
            open_hi.delete();
         end else if (roll < 10) begin
            pending_items.push_back(edge_item($urandom_range(0, 32767), $urandom,
                                              $urandom, 1'($urandom)));
         end else begin
            sweep_x = sweep_x + $urandom_range(0, 70);
            if (sweep_x > 32767) sweep_x = 32767;
            if (open_lo.size() > 0 && (open_lo.size() >= MAX_OPEN || roll < 50)) begin
               pick = $urandom_range(0, open_lo.size() - 1);
               pending_items.push_back(edge_item(sweep_x, open_lo[pick], open_hi[pick], 1));
               open_lo.delete(pick);
               open_hi.delete(pick);
            end else begin
               lo_v = $urandom_range(0, 32767);
               if (roll < 60) hi_v = lo_v + $urandom_range(0, 32767);
               else hi_v = lo_v + $urandom_range(0, 2000);
               if (hi_v > 32767) hi_v = 32767;
               open_lo.push_back(lo_v);
               open_hi.push_back(hi_v);
               pending_items.push_back(edge_item(sweep_x, lo_v, hi_v, 0));
            end
         end
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !req_valid && expected_rsp.size() == 0);
      repeat (2000) @(posedge clock);
      $display("sent %0d items (%0d clears), checked %0d results, %0d mismatches",
               items_sent, clears_sent, rsp_seen, mismatches);
      $display("covered directed span extremes plus random well-formed sweeps and noise");
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // driver
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(sweep_predict(req_data));
            items_sent++;
            if (req_data.action == ACTION_CLEAR) clears_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 300);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern
   int stall_mode = 0;
   int stall_run = 0;

   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run = $urandom_range(50, 1500);
      end else begin
         stall_run--;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 1) == 0);
         end
         default: begin
            rsp_stall <= ((cycles % 200) < 150);
         end
      endcase
   end

   // monitor
   rsp_type want;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %p", rsp_data);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.area !== want.area || rsp_data.fault !== want.fault ||
                rsp_data.covered_length !== want.covered_length) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected area %0d len %0d fault %0d, got %0d %0d %0d",
                           rsp_seen, want.area, want.covered_length, want.fault,
                           rsp_data.area, rsp_data.covered_length, rsp_data.fault);
            end
         end
      end
   end

endmodule

### rectangle_union_area_sweep_top.f
hdl/rua_pkg.sv
hdl/rua_ram.sv
hdl/rua_ctrl.sv
hdl/rua_dp.sv
hdl/rectangle_union_area_sweep_top.sv
verif/tb_top.sv
